FILE: rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
`default_nettype none
package rmq_pkg;

  localparam int NUM_W     = 17;  // off-diagonal sum or difference
  localparam int RAD_W     = 30;  // square root operand, (s << 12) padded to even width
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 1;
  localparam int DVD_W     = NUM_W + 12;
  localparam int SQ_CELLS  = ROOT_W;
  localparam int DIV_CELLS = DVD_W;
  localparam int NLANES    = 3;
  localparam int Q_W       = 16;
  localparam logic signed [18:0] ONE_Q = 19'sd16384;

  typedef struct packed {
    logic                               valid;
    logic [1:0]                         slot;   // output slot of the root component
    logic                               deg;
    logic [NLANES-1:0][NUM_W-1:0]       num;    // numerators, ascending output slots
    logic [RAD_W-1:0]                   rad;
    logic [REM_W-1:0]                   rem;
    logic [ROOT_W-1:0]                  root;
  } sq_t;

  typedef struct packed {
    logic               neg;
    logic [ROOT_W-1:0]  rem;
    logic [DVD_W-1:0]   dvd;
    logic [DVD_W-1:0]   quo;
  } lane_t;

  typedef struct packed {
    logic                     valid;
    logic [1:0]               slot;
    logic                     deg;
    logic [ROOT_W-1:0]        d;
    logic [NLANES-1:0][$bits(lane_t)-1:0] lane;
  } dv_t;

endpackage
`default_nettype wire

FILE: rtl/rmq_sqrt_cell.sv
// One digit of the restoring square root, registered.
`default_nettype none
module rmq_sqrt_cell (
  input  wire            clk,
  input  wire            rst,
  input  wire            en,
  input  rmq_pkg::sq_t   din,
  output rmq_pkg::sq_t   dout
);
  import rmq_pkg::*;

  logic [REM_W+2:0] diff;
  logic             ge;
  logic [REM_W+1:0] shifted;
  sq_t              dout_next;

  always_comb begin
    shifted = {din.rem, din.rad[RAD_W-1 -: 2]};
    diff = {1'b0, shifted} - {2'b00, din.root, 2'b01};
    ge = ~diff[REM_W+2];
    dout_next = din;
    dout_next.valid = din.valid & ~rst;
    dout_next.rad = {din.rad[RAD_W-3:0], 2'b00};
    dout_next.rem = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    dout_next.root = {din.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end else if (rst) begin
      dout.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rmq_div_cell.sv
// One quotient bit of the restoring division for all three lanes, registered.
`default_nettype none
module rmq_div_cell (
  input  wire            clk,
  input  wire            rst,
  input  wire            en,
  input  rmq_pkg::dv_t   din,
  output rmq_pkg::dv_t   dout
);
  import rmq_pkg::*;

  dv_t dout_next;

  always_comb begin
    lane_t            li;
    lane_t            lo;
    logic [ROOT_W+1:0] t;
    logic             ge;
    dout_next = din;
    dout_next.valid = din.valid & ~rst;
    for (int n = 0; n < NLANES; n++) begin
      li = lane_t'(din.lane[n]);
      t = {1'b0, li.rem, li.dvd[DVD_W-1]} - {2'b00, din.d};
      ge = ~t[ROOT_W+1];
      lo = li;
      lo.rem = ge ? t[ROOT_W-1:0] : {li.rem[ROOT_W-2:0], li.dvd[DVD_W-1]};
      lo.dvd = {li.dvd[DVD_W-2:0], 1'b0};
      lo.quo = {li.quo[DVD_W-2:0], ge};
      dout_next.lane[n] = lo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end else if (rst) begin
      dout.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion.sv
// Pipeline: 1 setup stage, 15 root cells, 29 divider cells and 1 output register.
// Throughput: one matrix per cycle; every stage advances together whenever the output
// register is empty or being taken, so a stall holds the whole chain.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
`default_nettype none
module rotation_matrix_to_quaternion (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [143:0] s_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [63:0]  m_tdata,   // qw, qx, qy, qz
  output logic [0:0]   m_tuser    // degenerate
);
  import rmq_pkg::*;

  logic signed [15:0] m [3][3];
  logic signed [17:0] trace;
  logic signed [18:0] s;
  logic signed [15:0] dii, djj, dkk;
  logic [1:0]         axis;
  logic               advance;
  sq_t                entry;
  sq_t                sq_pipe [SQ_CELLS+1];
  dv_t                dv_pipe [DIV_CELLS+1];
  logic [63:0]        res_next;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[r][c] = s_tdata[(r*3+c)*16 +: 16];
      end
    end
  end

  assign advance  = ~m_tvalid | m_tready;
  assign s_tready = advance & ~rst;

  // Pick the case, the root operand and the three numerators in output slot order.
  always_comb begin
    entry = '0;
    trace = 18'(m[0][0]) + 18'(m[1][1]) + 18'(m[2][2]);
    axis = 2'd0;
    if (m[1][1] > m[0][0]) begin
      axis = 2'd1;
    end
    if (m[2][2] > ((axis == 2'd1) ? m[1][1] : m[0][0])) begin
      axis = 2'd2;
    end
    unique case (axis)
      2'd0: begin dii = m[0][0]; djj = m[1][1]; dkk = m[2][2]; end
      2'd1: begin dii = m[1][1]; djj = m[2][2]; dkk = m[0][0]; end
      default: begin dii = m[2][2]; djj = m[0][0]; dkk = m[1][1]; end
    endcase
    entry.valid = s_tvalid & ~rst;
    if (trace > 18'sd0) begin
      s = 19'(trace) + ONE_Q;
      entry.slot = 2'd0;
      entry.num[0] = 17'(m[2][1]) - 17'(m[1][2]);
      entry.num[1] = 17'(m[0][2]) - 17'(m[2][0]);
      entry.num[2] = 17'(m[1][0]) - 17'(m[0][1]);
    end else begin
      s = 19'(dii) - 19'(djj) - 19'(dkk) + ONE_Q;
      entry.slot = axis + 2'd1;
      unique case (axis)
        2'd0: begin
          entry.num[0] = 17'(m[2][1]) - 17'(m[1][2]);
          entry.num[1] = 17'(m[1][0]) + 17'(m[0][1]);
          entry.num[2] = 17'(m[2][0]) + 17'(m[0][2]);
        end
        2'd1: begin
          entry.num[0] = 17'(m[0][2]) - 17'(m[2][0]);
          entry.num[1] = 17'(m[0][1]) + 17'(m[1][0]);
          entry.num[2] = 17'(m[2][1]) + 17'(m[1][2]);
        end
        default: begin
          entry.num[0] = 17'(m[1][0]) - 17'(m[0][1]);
          entry.num[1] = 17'(m[0][2]) + 17'(m[2][0]);
          entry.num[2] = 17'(m[1][2]) + 17'(m[2][1]);
        end
      endcase
    end
    entry.deg = (s <= 19'sd0);
    entry.rad = entry.deg ? '0 : {1'b0, s[16:0], 12'b0};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_pipe[0] <= entry;
    end else if (rst) begin
      sq_pipe[0].valid <= 1'b0;
    end
  end

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
    rmq_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .din  (sq_pipe[g]),
      .dout (sq_pipe[g+1])
    );
  end

  // Numerators become magnitude and sign; the root is the divisor.
  always_comb begin
    lane_t             ln;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  mag;
    dv_pipe[0].valid = sq_pipe[SQ_CELLS].valid;
    dv_pipe[0].slot  = sq_pipe[SQ_CELLS].slot;
    dv_pipe[0].deg   = sq_pipe[SQ_CELLS].deg;
    dv_pipe[0].d     = sq_pipe[SQ_CELLS].root;
    for (int n = 0; n < NLANES; n++) begin
      num = sq_pipe[SQ_CELLS].num[n];
      mag = num[NUM_W-1] ? (~num + 1'b1) : num;
      ln.neg = num[NUM_W-1];
      ln.rem = '0;
      ln.dvd = {mag, 12'b0};
      ln.quo = '0;
      dv_pipe[0].lane[n] = ln;
    end
  end

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    rmq_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .din  (dv_pipe[g]),
      .dout (dv_pipe[g+1])
    );
  end

  function automatic logic [Q_W-1:0] sat_q(input logic neg, input logic [DVD_W-1:0] q);
    logic [Q_W-1:0] v;
    if (!neg) begin
      v = (q > DVD_W'(32767)) ? 16'h7fff : q[Q_W-1:0];
    end else begin
      v = (q > DVD_W'(32768)) ? 16'h8000 : (~q[Q_W-1:0] + 16'd1);
    end
    return v;
  endfunction

  always_comb begin
    lane_t      ln;
    logic [1:0] li;
    res_next = '0;
    for (int r = 0; r < 4; r++) begin
      li = 2'(r) - ((2'(r) > dv_pipe[DIV_CELLS].slot) ? 2'd1 : 2'd0);
      ln = lane_t'(dv_pipe[DIV_CELLS].lane[li[0] ? 1 : (li[1] ? 2 : 0)]);
      if (2'(r) == dv_pipe[DIV_CELLS].slot) begin
        res_next[r*16 +: 16] = {1'b0, dv_pipe[DIV_CELLS].d};
      end else if (dv_pipe[DIV_CELLS].deg) begin
        res_next[r*16 +: 16] = '0;
      end else begin
        res_next[r*16 +: 16] = sat_q(ln.neg, ln.quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= res_next;
      m_tuser[0] <= dv_pipe[DIV_CELLS].deg;
      m_tvalid   <= dv_pipe[DIV_CELLS].valid & ~rst;
    end else if (rst) begin
      m_tvalid <= 1'b0;
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
    else $error("degenerate result carries a nonzero component");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    dv_pipe[0].valid && !dv_pipe[0].deg |-> dv_pipe[0].d != '0)
    else $error("zero divisor on a normal item");

  a_chain_out: assert property (@(posedge clk) disable iff (rst)
    advance && dv_pipe[DIV_CELLS].valid |=> m_tvalid)
    else $error("finished item lost at the output register");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(sq_pipe[0]) && $stable(dv_pipe[1]))
    else $error("pipeline moved while the output was stalled");

endmodule
`default_nettype wire

FILE: test/rotation_matrix_to_quaternion_tb.sv
// Self-checking testbench for the rotation matrix to quaternion pipeline.
`default_nettype none
module rotation_matrix_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 46;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_RANDOM = 500;
  localparam logic signed [15:0] Q_ONE = 16'sd16384;

  typedef struct packed {
    logic       deg;
    logic [15:0] qz;
    logic [15:0] qy;
    logic [15:0] qx;
    logic [15:0] qw;
  } quat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [0:0]   m_tuser;

  quat_t expected_quats[$];
  int mismatches = 0;
  int unexpected = 0;
  int results_seen = 0;
  int deg_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint int_sqrt(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v) r += longint'(1) << b;
    end
    return r;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint scaled_quotient(longint num, longint den);
    if (den <= 0) return 0;
    // SystemVerilog division truncates toward zero.
    return clamp16((num * 4096) / den);
  endfunction

  function automatic quat_t matrix_to_quat(logic [143:0] data);
    longint m[3][3];
    longint q[3];
    longint w, tr, c, s;
    int i, j, k;
    quat_t res;
    for (int n = 0; n < 9; n++) m[n / 3][n % 3] = longint'($signed(data[16*n +: 16]));
    tr = m[0][0] + m[1][1] + m[2][2];
    res.deg = 1'b0;
    if (tr > 0) begin
      c = int_sqrt((tr + 16384) * 4096);
      w = clamp16(c);
      q[0] = scaled_quotient(m[2][1] - m[1][2], c);
      q[1] = scaled_quotient(m[0][2] - m[2][0], c);
      q[2] = scaled_quotient(m[1][0] - m[0][1], c);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      s = m[i][i] - m[j][j] - m[k][k] + 16384;
      res.deg = (s <= 0);
      c = (s > 0) ? int_sqrt(s * 4096) : 0;
      q[i] = clamp16(c);
      w = scaled_quotient(m[k][j] - m[j][k], c);
      q[j] = scaled_quotient(m[j][i] + m[i][j], c);
      q[k] = scaled_quotient(m[k][i] + m[i][k], c);
    end
    res.qw = w[15:0];
    res.qx = q[0][15:0];
    res.qy = q[1][15:0];
    res.qz = q[2][15:0];
    return res;
  endfunction

  function automatic logic [143:0] pack_matrix(logic signed [15:0] a, b, c, d, e, f, g, h, p);
    return {p, h, g, f, e, d, c, b, a};
  endfunction

  function automatic logic [143:0] random_matrix();
    logic [143:0] v;
    int mode;
    mode = $urandom_range(0, 9);
    for (int n = 0; n < 9; n++) begin
      if (mode < 6) v[16*n +: 16] = 16'($signed($urandom_range(0, 32768)) - 16384);
      else v[16*n +: 16] = 16'($urandom);
    end
    return v;
  endfunction

  // Directed rows: data plus an optional typed-in result.
  typedef struct {
    logic [143:0] data;
    bit           known;
    quat_t        result;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic send_matrix(logic [143:0] data);
    s_tdata <= data;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_quats.push_back(matrix_to_quat(data));
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    quat_t id_q;
    stim_row_t row;
    id_q = '{deg: 1'b0, qw: Q_ONE / 2 * 2, qx: '0, qy: '0, qz: '0};
    row.known = 1'b1; row.result = id_q;
    row.data = pack_matrix(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE);
    directed.push_back(row);
    // A zero matrix falls to the x branch with a root component of one half.
    row.result = '0;
    row.result.qx = 16'd8192;
    row.data = '0;
    directed.push_back(row);
    row.known = 1'b0;
    row.data = {9{16'h8000}};
    directed.push_back(row);
    // 180 degree turns about each axis select each diagonal branch.
    directed.push_back('{pack_matrix(Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, -Q_ONE), 0, '0});
    directed.push_back('{pack_matrix(-Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, -Q_ONE), 0, '0});
    directed.push_back('{pack_matrix(-Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, Q_ONE), 0, '0});
    // Ties on the diagonal keep the earlier index.
    directed.push_back('{pack_matrix(0, 100, -200, 300, 0, 50, 7, -9, 0), 0, '0});
    directed.push_back('{pack_matrix(-5, 1, 2, 3, 4, 5, 6, 7, 4), 0, '0});
    directed.push_back('{{9{16'h7fff}}, 0, '0});
    directed.push_back('{pack_matrix(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                     16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff), 0, '0});
    directed.push_back('{pack_matrix(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                     16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000), 0, '0});
    directed.push_back('{pack_matrix(-1, 32767, -32768, -32768, -1, 32767, 32767, -32768, 1),
                         0, '0});
    directed.push_back('{pack_matrix(1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{pack_matrix(0, 0, 0, 0, 0, 0, 0, 0, -16384), 0, '0});
    directed.push_back('{pack_matrix(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384), 0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[n]) begin
      send_matrix(directed[n].data);
      if (directed[n].known) expected_quats[$] = directed[n].result;
      pause_sender();
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      send_matrix(random_matrix());
      if (n == NUM_RANDOM / 2) hold_off = 1'b1;
      if (n < NUM_RANDOM - 1) pause_sender();
    end
    s_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stalls, with one long hold-off so the pipeline fills and backs up.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (($urandom_range(0, 3) == 0) || gap == 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata[63:48], m_tdata[47:32], m_tdata[31:16], m_tdata[15:0]};
      results_seen++;
      if (got.deg) deg_seen++;
      if (expected_quats.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) $display("Unexpected transaction: %h", got);
      end else begin
        want = expected_quats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("Mismatch: qw %h/%h qx %h/%h qy %h/%h qz %h/%h deg %b/%b (exp/act)",
                     want.qw, got.qw, want.qx, got.qx, want.qy, got.qy, want.qz, got.qz,
                     want.deg, got.deg);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk);
    wait (stim_done && expected_quats.size() == 0 || idle_cycles >= WATCHDOG_LIMIT);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout with %0d results outstanding.", expected_quats.size());
      $display("rotation_matrix_to_quaternion test failed");
    end else begin
      repeat (LATENCY * 2) @(posedge clk);
      $display("Checked %0d matrices (%0d degenerate) across all branches, saturation,",
               results_seen, deg_seen);
      $display("random gaps and a long output stall.");
      if (mismatches == 0 && unexpected == 0 && expected_quats.size() == 0)
        $display("rotation_matrix_to_quaternion test passed");
      else
        $display("rotation_matrix_to_quaternion test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/rmq_pkg.sv
rtl/rmq_sqrt_cell.sv
rtl/rmq_div_cell.sv
rtl/rotation_matrix_to_quaternion.sv
test/rotation_matrix_to_quaternion_tb.sv
